// ===== src/wbsl_pkg.sv =====
// Package for the wind blend and slew limiter.
// Holds the sequencer state type, register indexes and fixed blend constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wbsl_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_DIV,
        ST_CHK,
        ST_FIX,
        ST_BLE,
        ST_BLN,
        ST_TN,
        ST_SLEW
    } wbsl_state_t;

    // configuration register indexes
    localparam logic [2:0] REG_GLOBAL_EAST  = 3'd0;
    localparam logic [2:0] REG_GLOBAL_NORTH = 3'd1;
    localparam logic [2:0] REG_LOCAL_EAST   = 3'd2;
    localparam logic [2:0] REG_LOCAL_NORTH  = 3'd3;
    localparam logic [2:0] REG_SHEAR_EN     = 3'd4;
    localparam logic [2:0] REG_SHEAR_HEIGHT = 3'd5;
    localparam logic [2:0] REG_MAX_STEP     = 3'd6;

    localparam logic [14:0] MAX_STEP_RESET = 15'd102;

    // boundaries: 3500 ft in quarter metres, 10 nmi in metres
    localparam logic signed [17:0] HT_BOUND_QM  = 18'sd4267;
    localparam logic [17:0]        DIST_BOUND_M = 18'd18520;
    localparam logic signed [21:0] HT_BOUND_NUM = 22'sd21336;

    // blend denominator 21336 * 18520
    localparam logic signed [40:0] BLEND_DEN    = 41'sd395142720;
    localparam logic [16:0]        Q16_ONE      = 17'h10000;

    // BLEND_DEN = 64 * BLEND_ODD, so the Q16 fraction is num * 1024 / BLEND_ODD
    localparam logic signed [23:0] BLEND_ODD    = 24'sd6174105;
    // floor(2^40 / BLEND_ODD)
    localparam logic signed [18:0] BLEND_RECIP  = 19'sd178084;

endpackage

`default_nettype wire

// ===== src/wind_blend_slew_limiter_unit.sv =====
// Top level of the wind blend and slew limiter: stream ports, config port,
// sequencer and the shared multiplier. Depends on wbsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One frame in, one kept wind out. A clear beat (tuser = 1) or a frame that
// selects the global wind passes through the accept state and the slew state.
// A blended frame passes through the accept state, two products for the
// blend fraction on the shared 24 x 19 multiplier, one add and range check,
// the Q16 fraction steps (a reciprocal product, a back-multiply and a one-step
// correction), two blend products, a state to form the north target and the
// slew state. A fraction that saturates at 0 or 1 skips the fraction steps,
// going straight to the blend products. s_tready is high only
// while the sequencer is idle; a finished result sits in the output register
// until taken, and the sequencer holds in its slew state only while the
// previous result is still waiting. Configuration writes are always ready.
module wind_blend_slew_limiter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] in_boundary, [18:1] height_above_origin, [36:19] horizontal_distance
    input  wire logic [39:0] s_tdata,
    // [0] op
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] wind_east, [31:16] wind_north
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    import wbsl_pkg::*;

    wbsl_state_t state_reg, state_next;

    logic signed [15:0] ge_reg, gn_reg, le_reg, ln_reg;
    logic               shear_en_reg;
    logic [16:0]        shear_h_reg;
    logic [14:0]        max_step_reg;

    logic signed [15:0] last_e_reg, last_e_next, last_n_reg, last_n_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg, out_data_next;

    logic signed [17:0] h_reg, h_next;
    logic [17:0]        d_reg, d_next;
    logic signed [40:0] prod_reg, prod_next, acc_reg, acc_next;
    logic [28:0]        numer_reg, numer_next;
    logic [16:0]        f_reg, f_next;
    logic signed [15:0] te_reg, te_next, tn_reg, tn_next;
    logic               clr_reg, clr_next;

    logic signed [23:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [40:0] mul_p;

    function automatic logic signed [15:0] slew_step(
        input logic signed [15:0] last,
        input logic signed [15:0] tgt,
        input logic [14:0]        lim
    );
        logic signed [16:0] delta;
        logic signed [16:0] lim17;
        logic signed [15:0] lim16;
        delta = 17'(tgt) - 17'(last);
        lim17 = $signed({2'b00, lim});
        lim16 = $signed({1'b0, lim});
        if (delta > lim17) begin
            slew_step = last + lim16;
        end else if (delta < -lim17) begin
            slew_step = last - lim16;
        end else begin
            slew_step = tgt;
        end
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // shared multiplier operand select
    always_comb begin
        logic signed [23:0] h_ext;
        h_ext = 24'(h_reg);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL1: begin
                mul_a = (h_ext <<< 2) + h_ext;
                mul_b = $signed({1'b0, DIST_BOUND_M}) - $signed({1'b0, d_reg});
            end
            ST_MUL2: begin
                mul_a = 24'(HT_BOUND_NUM);
                mul_b = $signed({1'b0, d_reg});
            end
            ST_DIV: begin
                // top bits of the numerator times the reciprocal
                mul_a = $signed({5'b0, numer_reg[28:10]});
                mul_b = BLEND_RECIP;
            end
            ST_CHK: begin
                mul_a = BLEND_ODD;
                mul_b = $signed({3'b0, f_reg[15:0]});
            end
            ST_BLE: begin
                mul_a = $signed({7'b0, f_reg});
                mul_b = 19'(ge_reg) - 19'(le_reg);
            end
            ST_BLN: begin
                mul_a = $signed({7'b0, f_reg});
                mul_b = 19'(gn_reg) - 19'(ln_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 41'(mul_a) * 41'(mul_b);

    always_comb begin
        logic               in_b;
        logic signed [17:0] h_in;
        logic [17:0]        d_in;
        logic               use_global;
        logic signed [40:0] num;
        logic signed [40:0] fix_rem;
        logic signed [16:0] blend_sum;
        logic signed [15:0] se, sn;

        in_b = s_tdata[0];
        h_in = $signed(s_tdata[18:1]);
        d_in = s_tdata[36:19];
        use_global = !in_b || (h_in > HT_BOUND_QM) || (d_in > DIST_BOUND_M) ||
                     (shear_en_reg && (h_in > $signed({1'b0, shear_h_reg})));
        num       = acc_reg + prod_reg;
        fix_rem   = $signed({2'b00, numer_reg, 10'b0}) - prod_reg;
        blend_sum = '0;
        se        = slew_step(last_e_reg, te_reg, max_step_reg);
        sn        = slew_step(last_n_reg, tn_reg, max_step_reg);

        state_next     = state_reg;
        h_next         = h_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        numer_next     = numer_reg;
        f_next         = f_reg;
        te_next        = te_reg;
        tn_next        = tn_reg;
        clr_next       = clr_reg;
        last_e_next    = last_e_reg;
        last_n_next    = last_n_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    h_next = h_in;
                    d_next = d_in;
                    if (s_tuser[0]) begin
                        clr_next   = 1'b1;
                        state_next = ST_SLEW;
                    end else if (use_global) begin
                        clr_next   = 1'b0;
                        te_next    = ge_reg;
                        tn_next    = gn_reg;
                        state_next = ST_SLEW;
                    end else begin
                        clr_next   = 1'b0;
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                prod_next  = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (num <= 0) begin
                    f_next     = '0;
                    state_next = ST_BLE;
                end else if (num >= BLEND_DEN) begin
                    f_next     = Q16_ONE;
                    state_next = ST_BLE;
                end else begin
                    numer_next = num[28:0];
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // estimate is the true quotient or one below it
                f_next     = {1'b0, mul_p[35:20]};
                state_next = ST_CHK;
            end
            ST_CHK: begin
                prod_next  = mul_p;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                // bump the estimate when a whole divisor is left over
                if (fix_rem >= 41'(BLEND_ODD)) begin
                    f_next = f_reg + 17'd1;
                end
                state_next = ST_BLE;
            end
            ST_BLE: begin
                prod_next  = mul_p;
                state_next = ST_BLN;
            end
            ST_BLN: begin
                // arithmetic shift floors toward minus infinity
                blend_sum  = 17'(le_reg) + $signed(prod_reg[32:16]);
                te_next    = blend_sum[15:0];
                prod_next  = mul_p;
                state_next = ST_TN;
            end
            ST_TN: begin
                blend_sum  = 17'(ln_reg) + $signed(prod_reg[32:16]);
                tn_next    = blend_sum[15:0];
                state_next = ST_SLEW;
            end
            ST_SLEW: begin
                // hold while the previous result still waits
                if (!out_valid_reg || m_tready) begin
                    if (clr_reg) begin
                        last_e_next = '0;
                        last_n_next = '0;
                    end else begin
                        last_e_next = se;
                        last_n_next = sn;
                    end
                    out_data_next  = {last_n_next, last_e_next};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_e_reg    <= '0;
            last_n_reg    <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            last_e_reg    <= last_e_next;
            last_n_reg    <= last_n_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg        <= h_next;
        d_reg        <= d_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        numer_reg    <= numer_next;
        f_reg        <= f_next;
        te_reg       <= te_next;
        tn_reg       <= tn_next;
        clr_reg      <= clr_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ge_reg       <= '0;
            gn_reg       <= '0;
            le_reg       <= '0;
            ln_reg       <= '0;
            shear_en_reg <= 1'b0;
            shear_h_reg  <= '0;
            max_step_reg <= MAX_STEP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GLOBAL_EAST:  ge_reg       <= $signed(cfg_data[15:0]);
                REG_GLOBAL_NORTH: gn_reg       <= $signed(cfg_data[15:0]);
                REG_LOCAL_EAST:   le_reg       <= $signed(cfg_data[15:0]);
                REG_LOCAL_NORTH:  ln_reg       <= $signed(cfg_data[15:0]);
                REG_SHEAR_EN:     shear_en_reg <= cfg_data[0];
                REG_SHEAR_HEIGHT: shear_h_reg  <= cfg_data;
                REG_MAX_STEP:     max_step_reg <= cfg_data[14:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/wbsl_checker.sv =====
// Port-level checker for the wind blend and slew limiter, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module wbsl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // the sequencer is busy in the cycle after taking a frame
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting a frame");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // no result can appear in the cycle right after a frame is accepted
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after accept");

    // register writes never wait
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("register write held off");

endmodule

bind wind_blend_slew_limiter_unit wbsl_checker u_wbsl_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for wind_blend_slew_limiter_unit: a directed table, then random
// frames under several register settings, scored against an in-bench wind predictor.
// Depends on wbsl_pkg and the unit itself.

module testbench;
    import wbsl_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_FRAMES  = 150;
    localparam int NUM_PHASES    = 6;
    localparam int HOLD_AT_FRAME = 20;
    localparam int FIRST_SET_ROW = 2;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic signed [15:0] east;
        logic signed [15:0] north;
    } wind_t;

    typedef struct {
        logic op;
        logic inb;
        int   h;
        int   d;
        bit   known;
        int   east;
        int   north;
    } frame_row_t;

    typedef struct {
        int ge, gn, le, ln;
        bit shear_on;
        int shear_alt;
        int step;
        bit calm;
        bit hold;
    } setting_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire         cfg_ready;

    // predictor copy of the registers and the kept wind
    logic signed [15:0] glob_e = '0, glob_n = '0, loc_e = '0, loc_n = '0;
    logic signed [15:0] kept_e = '0, kept_n = '0;
    logic               shear_on = 1'b0;
    logic [16:0]        shear_alt = '0;
    logic [14:0]        step_lim = MAX_STEP_RESET;

    wind_t expected_winds[$];
    wind_t oldest;
    bit    calm = 1'b0;
    bit    hold_wanted = 1'b0;
    int    stall_cycles = 0;
    int    mismatches = 0;
    int    results_checked = 0;
    int    frames_sent = 0;
    int    clears_sent = 0;
    int    blended_frames = 0;
    int    settings_used = 0;

    // east/north of 1000/-1000 global and 200/-300 local once configured
    frame_row_t directed_rows [17] = '{
        '{OP_UPDATE, 1'b1, 0, 0, 1'b1, 0, 0},
        '{OP_CLEAR, 1'b1, 100, 100, 1'b1, 0, 0},
        '{OP_UPDATE, 1'b0, 0, 0, 1'b1, 1000, -1000},
        '{OP_CLEAR, 1'b0, -1, 262143, 1'b1, 0, 0},
        '{OP_UPDATE, 1'b1, 4268, 0, 1'b1, 1000, -1000},
        '{OP_UPDATE, 1'b1, 0, 18521, 1'b1, 1000, -1000},
        '{OP_UPDATE, 1'b1, 0, 0, 1'b1, 200, -300},
        '{OP_UPDATE, 1'b1, -131072, 0, 1'b1, 200, -300},
        '{OP_UPDATE, 1'b1, 131071, 262143, 1'b1, 1000, -1000},
        '{OP_UPDATE, 1'b1, 3000, 0, 1'b0, 0, 0},
        '{OP_UPDATE, 1'b1, 3001, 0, 1'b1, 1000, -1000},
        '{OP_UPDATE, 1'b1, 0, 18520, 1'b1, 1000, -1000},
        '{OP_UPDATE, 1'b1, -131072, 18520, 1'b0, 0, 0},
        '{OP_UPDATE, 1'b1, 1000, 5000, 1'b0, 0, 0},
        '{OP_UPDATE, 1'b1, 2500, 12000, 1'b0, 0, 0},
        '{OP_CLEAR, 1'b0, 0, 0, 1'b1, 0, 0},
        '{OP_UPDATE, 1'b1, -5, 3, 1'b0, 0, 0}
    };

    setting_t directed_setting = '{1000, -1000, 200, -300, 1'b1, 3000, 32767, 1'b0, 1'b0};

    wind_blend_slew_limiter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic void mirror_reg(logic [2:0] idx, logic [16:0] val);
        case (idx)
            REG_GLOBAL_EAST:  glob_e = val[15:0];
            REG_GLOBAL_NORTH: glob_n = val[15:0];
            REG_LOCAL_EAST:   loc_e = val[15:0];
            REG_LOCAL_NORTH:  loc_n = val[15:0];
            REG_SHEAR_EN:     shear_on = val[0];
            REG_SHEAR_HEIGHT: shear_alt = val;
            REG_MAX_STEP:     step_lim = val[14:0];
            default: ;
        endcase
    endfunction

    // local + floor(frac * (global - local) / 2^16)
    function automatic logic signed [15:0] mix_toward(logic signed [15:0] loc,
                                                      logic signed [15:0] glob,
                                                      longint frac);
        longint prod;
        prod = frac * (longint'(glob) - longint'(loc));
        return 16'(longint'(loc) + (prod >>> 16));
    endfunction

    function automatic logic signed [15:0] slew_toward(logic signed [15:0] last,
                                                       logic signed [15:0] target);
        int delta;
        int lim;
        delta = int'(target) - int'(last);
        lim   = int'(step_lim);
        if (delta > lim)
            return 16'(int'(last) + lim);
        if (delta < -lim)
            return 16'(int'(last) - lim);
        return target;
    endfunction

    function automatic wind_t advance_kept_wind(logic op, logic inb,
                                                logic signed [17:0] h, logic [17:0] d);
        longint num;
        longint frac;
        bit     to_global;
        wind_t  target;
        wind_t  kept;
        if (op) begin
            kept_e = '0;
            kept_n = '0;
        end else begin
            to_global = !inb || (int'(h) > int'(HT_BOUND_QM)) || (d > DIST_BOUND_M) ||
                        (shear_on && (longint'(h) > longint'(shear_alt)));
            if (to_global) begin
                target.east  = glob_e;
                target.north = glob_n;
            end else begin
                blended_frames++;
                num = 5 * longint'(h) * (longint'(DIST_BOUND_M) - longint'(d)) +
                      longint'(HT_BOUND_NUM) * longint'(d);
                if (num <= 0)
                    frac = 0;
                else if (num >= longint'(BLEND_DEN))
                    frac = longint'(Q16_ONE);
                else
                    frac = (num * longint'(Q16_ONE)) / longint'(BLEND_DEN);
                target.east  = mix_toward(loc_e, glob_e, frac);
                target.north = mix_toward(loc_n, glob_n, frac);
            end
            kept_e = slew_toward(kept_e, target.east);
            kept_n = slew_toward(kept_n, target.north);
        end
        kept.east  = kept_e;
        kept.north = kept_n;
        return kept;
    endfunction

    task automatic pause_until_drained();
        while (expected_winds.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        mirror_reg(idx, val);
    endtask

    task automatic apply_setting(setting_t s);
        pause_until_drained();
        write_reg(REG_GLOBAL_EAST, 17'(s.ge));
        write_reg(REG_GLOBAL_NORTH, 17'(s.gn));
        write_reg(REG_LOCAL_EAST, 17'(s.le));
        write_reg(REG_LOCAL_NORTH, 17'(s.ln));
        write_reg(REG_SHEAR_EN, 17'(s.shear_on));
        write_reg(REG_SHEAR_HEIGHT, 17'(s.shear_alt));
        write_reg(REG_MAX_STEP, 17'(s.step));
        // an unmapped index must leave every register alone
        write_reg(REG_UNUSED, 17'($urandom));
        cfg_valid <= 1'b0;
        calm = s.calm;
        settings_used++;
    endtask

    task automatic send_frame(logic op, logic inb, logic signed [17:0] h, logic [17:0] d,
                              bit known = 1'b0, wind_t typed = '0);
        wind_t predicted;
        predicted = advance_kept_wind(op, inb, h, d);
        expected_winds.push_back(known ? typed : predicted);
        frames_sent++;
        if (op == OP_CLEAR)
            clears_sent++;
        while (!calm && ($urandom_range(99) < 25)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, d, h, inb};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;

        if (aresetn && m_tvalid && m_tready) begin
            if (expected_winds.size() == 0) begin
                $error("unexpected result beat: wind_east %0d, wind_north %0d",
                       $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
                mismatches++;
            end else begin
                oldest = expected_winds.pop_front();
                results_checked++;
                if (m_tdata[15:0] !== oldest.east) begin
                    $error("wind_east: expected %0d, got %0d",
                           oldest.east, $signed(m_tdata[15:0]));
                    mismatches++;
                end
                if (m_tdata[31:16] !== oldest.north) begin
                    $error("wind_north: expected %0d, got %0d",
                           oldest.north, $signed(m_tdata[31:16]));
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("No beat moved for %0d cycles, %0d results still pending",
                 STALL_LIMIT, expected_winds.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        setting_t           s;
        wind_t              typed;
        logic               op;
        logic               inb;
        logic signed [17:0] h;
        logic [17:0]        d;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(directed_rows); i++) begin
            if (i == FIRST_SET_ROW) begin
                s_tvalid <= 1'b0;
                apply_setting(directed_setting);
            end
            typed.east  = 16'(directed_rows[i].east);
            typed.north = 16'(directed_rows[i].north);
            send_frame(directed_rows[i].op, directed_rows[i].inb, 18'(directed_rows[i].h),
                       18'(directed_rows[i].d), directed_rows[i].known, typed);
        end
        s_tvalid <= 1'b0;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: s = '{32767, -32768, -32768, 32767, 1'b0, 131071, 32767, 1'b0, 1'b0};
                1: s = '{int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                         int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                         1'b1, int'($urandom_range(4267)), 102, 1'b1, 1'b1};
                2: s = '{-32768, -32768, 32767, 32767, 1'b1, 0, 0, 1'b0, 1'b0};
                3: s = '{int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                         int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                         bit'($urandom_range(1)), int'($urandom_range(131071)),
                         int'($urandom_range(2000)), 1'b0, 1'b1};
                4: s = '{int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                         int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                         1'b0, int'($urandom_range(131071)), 32767, 1'b0, 1'b0};
                default: s = '{0, 0, int'($urandom_range(65535)) - 32768,
                               int'($urandom_range(65535)) - 32768, 1'b1, 131071, 1, 1'b0, 1'b0};
            endcase
            apply_setting(s);

            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (s.hold && n == HOLD_AT_FRAME)
                    hold_wanted = 1'b1;
                op  = ($urandom_range(99) < 6) ? OP_CLEAR : OP_UPDATE;
                inb = ($urandom_range(99) < 85);
                // bias height toward the blend range and the two switch points
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: h = 18'($urandom_range(4267));
                    6: h = 18'(int'(HT_BOUND_QM) - 8 + int'($urandom_range(16)));
                    7: h = 18'(-int'($urandom_range(131072)));
                    8: h = 18'($urandom);
                    default: h = 18'(int'(shear_alt) - 3 + int'($urandom_range(6)));
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5, 6: d = 18'($urandom_range(18520));
                    7: d = 18'(int'(DIST_BOUND_M) - 5 + int'($urandom_range(10)));
                    default: d = 18'($urandom);
                endcase
                send_frame(op, inb, h, d);
            end
            s_tvalid <= 1'b0;
        end

        pause_until_drained();
        $display("Sent %0d frames (%0d clears, %0d blended) over %0d register settings",
                 frames_sent, clears_sent, blended_frames, settings_used);
        $display("Checked %0d result beats, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_winds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
